// ===== design/srpr_pkg.sv =====
// ----------------------------------------------------------------------------
// srpr_pkg
// Types and constants shared by the prefetch ring modules.
// ----------------------------------------------------------------------------
`default_nettype none
package srpr_pkg;

  localparam int SLOTS       = 8;
  localparam int MIN_SLOTS   = 2;
  localparam int TRACKERS    = 4;
  localparam int CHUNK_BYTES = 1048576;

  localparam int SLOT_W  = $clog2(SLOTS);
  localparam int TRK_W   = (TRACKERS > 1) ? $clog2(TRACKERS) : 1;
  localparam int DEPTH_W = $clog2(SLOTS + 1);
  localparam int MIN_DEPTH = (MIN_SLOTS < SLOTS) ? MIN_SLOTS : SLOTS;
  localparam int SCAN_N  = (SLOTS > TRACKERS) ? SLOTS : TRACKERS;
  localparam int SCAN_W  = (SCAN_N > 1) ? $clog2(SCAN_N) : 1;

  localparam logic [1:0] ACT_READ  = 2'd0;
  localparam logic [1:0] ACT_DONE  = 2'd1;
  localparam logic [1:0] ACT_CLOSE = 2'd2;

  localparam logic [2:0] KIND_MISS   = 3'd0;
  localparam logic [2:0] KIND_HIT    = 3'd1;
  localparam logic [2:0] KIND_PARK   = 3'd2;
  localparam logic [2:0] KIND_ISSUE  = 3'd3;
  localparam logic [2:0] KIND_WDONE  = 3'd4;

  localparam logic [1:0] CFG_FILE_SIZE = 2'd0;
  localparam logic [1:0] CFG_ARM       = 2'd1;
  localparam logic [1:0] CFG_REAIM     = 2'd2;
  localparam logic [1:0] CFG_ENABLE    = 2'd3;

  typedef enum logic [1:0] {
    SL_EMPTY  = 2'd0,
    SL_FLIGHT = 2'd1,
    SL_READY  = 2'd2
  } slot_st_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [47:0] read_offset;
    logic [20:0] read_length;
    logic [7:0]  request_tag;
    logic [2:0]  done_slot;
    logic        fetch_ok;
    logic [20:0] valid_bytes;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [2:0]  slot;
    logic [47:0] fetch_offset;
    logic [20:0] byte_count;
    logic [7:0]  done_tag;
    logic        done_ok;
    logic        last;
  } out_word_t;

  // pump step request and response between sequencer and pump unit
  typedef struct packed {
    logic [47:0] next_off;
    logic [47:0] file_size;
  } pump_req_t;

  typedef struct packed {
    logic        more;
    logic [47:0] off_next;
    logic [20:0] len;
  } pump_rsp_t;

endpackage
`default_nettype wire

// ===== design/sequential_read_prefetch_ring.sv =====
// ----------------------------------------------------------------------------
// sequential_read_prefetch_ring
// Prefetcher: stream trackers, slot ring, fetch pump under a sequencer.
// ----------------------------------------------------------------------------
// channel  | signals                       | rule
// in       | start, busy, in_word          | taken when start & !busy
// out      | out_valid, out_word           | one cycle, no backpressure
// cfg      | cfg_we, cfg_index, cfg_data   | written on cfg_we
// A read holds busy through the tracker scan over TRACKERS entries, update,
// decide and emit, plus the slot scan over SLOTS entries while a ring is open,
// plus up to depth_limit + 1 pump steps (never more than SLOTS). Results go
// out alongside the pump steps. A completion with a parked reader passes
// through the emit state; other completions and close are taken in the idle
// state. Reset clears all control state.
// The receiver cannot stall.
// ----------------------------------------------------------------------------
`default_nettype none
module sequential_read_prefetch_ring (
  input  var logic                 clk,
  input  var logic                 rst,
  input  var logic                 start,
  output logic                     busy,
  input  var srpr_pkg::in_word_t   in_word,
  output logic                     out_valid,
  output srpr_pkg::out_word_t      out_word,
  input  var logic                 cfg_we,
  input  var logic [1:0]           cfg_index,
  input  var logic [47:0]          cfg_data
);
  import srpr_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_TRK   = 7'b0000010,
    S_UPD   = 7'b0000100,
    S_SLOT  = 7'b0001000,
    S_DEC   = 7'b0010000,
    S_PUMP  = 7'b0100000,
    S_EMIT  = 7'b1000000
  } fsm_t;

  fsm_t state;

  logic [47:0] file_size;
  logic [7:0]  arm_streak;
  logic [15:0] reaim_idle_reads;
  logic        ring_enable;

  logic [47:0] tracker_end    [TRACKERS];
  logic [15:0] tracker_streak [TRACKERS];
  logic [31:0] read_clock;
  logic        ring_open;
  logic [7:0]  ring_generation;
  logic [47:0] next_fetch_offset;
  logic [DEPTH_W-1:0] depth_limit;
  logic [31:0] last_consume_clock;
  slot_st_t    slot_state [SLOTS];
  logic [47:0] slot_offset [SLOTS];
  logic [20:0] slot_length [SLOTS];
  logic [7:0]  slot_generation [SLOTS];
  logic [SLOTS-1:0] slot_waiting;
  logic [7:0]  waiter_tag [SLOTS];
  logic [20:0] waiter_length [SLOTS];

  in_word_t    cur;
  logic [SCAN_W-1:0] idx;
  logic [TRK_W-1:0] pick, cold;
  logic        found;
  logic [15:0] streak;
  logic        slot_hit;
  logic [SLOT_W-1:0] hit_slot;
  logic        pump_after_depth;
  logic [SLOT_W:0] pidx;
  out_word_t   pend;
  logic        pend_v;

  pump_req_t preq;
  pump_rsp_t prsp;
  assign preq.next_off  = next_fetch_offset;
  assign preq.file_size = file_size;
  srpr_pump u_pump (.req(preq), .rsp(prsp));

  assign busy = (state != S_IDLE);

  logic [SLOT_W-1:0] ps;
  logic [SLOT_W-1:0] ss;
  logic [TRK_W-1:0]  ts;
  assign ps = pidx[SLOT_W-1:0];
  assign ss = idx[SLOT_W-1:0];
  assign ts = idx[TRK_W-1:0];

  // main FSM; on each pump issue the previous pending word goes out and the new one becomes pending
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      file_size <= '0; arm_streak <= 8'd2; reaim_idle_reads <= 16'd8;
      ring_enable <= 1'b1;
      for (int t = 0; t < TRACKERS; t++) begin
        tracker_end[t] <= '0; tracker_streak[t] <= '0;
      end
      read_clock <= '0; ring_open <= 1'b0; ring_generation <= '0;
      next_fetch_offset <= '0; depth_limit <= DEPTH_W'(MIN_DEPTH);
      last_consume_clock <= '0;
      for (int s = 0; s < SLOTS; s++) begin
        slot_state[s] <= SL_EMPTY; slot_offset[s] <= '0;
        slot_length[s] <= '0; slot_generation[s] <= '0;
      end
      slot_waiting <= '0;
      out_valid <= 1'b0; pend_v <= 1'b0;
      idx <= '0; pidx <= '0; pick <= '0; cold <= '0; found <= 1'b0;
      streak <= '0; slot_hit <= 1'b0; hit_slot <= '0;
      pump_after_depth <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_FILE_SIZE: file_size <= cfg_data;
          CFG_ARM:       arm_streak <= cfg_data[7:0];
          CFG_REAIM:     reaim_idle_reads <= cfg_data[15:0];
          CFG_ENABLE:    ring_enable <= cfg_data[0];
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          out_valid <= 1'b0;
          if (start) begin
            cur <= in_word;
            idx <= '0; found <= 1'b0; cold <= '0;
            case (in_word.action)
              ACT_READ: state <= S_TRK;
              ACT_DONE: begin
                if (slot_state[in_word.done_slot[SLOT_W-1:0]] == SL_FLIGHT) begin
                  if (slot_waiting[in_word.done_slot[SLOT_W-1:0]]) begin
                    slot_waiting[in_word.done_slot[SLOT_W-1:0]] <= 1'b0;
                    slot_state[in_word.done_slot[SLOT_W-1:0]] <= SL_EMPTY;
                    pend.kind <= KIND_WDONE;
                    pend.slot <= in_word.done_slot;
                    pend.fetch_offset <= '0;
                    pend.byte_count <= !in_word.fetch_ok ? 21'd0 :
                      (waiter_length[in_word.done_slot[SLOT_W-1:0]] < in_word.valid_bytes
                       ? waiter_length[in_word.done_slot[SLOT_W-1:0]]
                       : in_word.valid_bytes);
                    pend.done_tag <= waiter_tag[in_word.done_slot[SLOT_W-1:0]];
                    pend.done_ok <= in_word.fetch_ok;
                    pend.last <= 1'b0;
                    pend_v <= 1'b1;
                    state <= S_EMIT;
                  end else if (in_word.fetch_ok &&
                      slot_generation[in_word.done_slot[SLOT_W-1:0]] == ring_generation) begin
                    slot_state[in_word.done_slot[SLOT_W-1:0]] <= SL_READY;
                    slot_length[in_word.done_slot[SLOT_W-1:0]] <= in_word.valid_bytes;
                  end else begin
                    slot_state[in_word.done_slot[SLOT_W-1:0]] <= SL_EMPTY;
                  end
                end
              end
              ACT_CLOSE: begin
                if (ring_open) begin
                  ring_open <= 1'b0;
                  ring_generation <= ring_generation + 8'd1;
                  for (int s = 0; s < SLOTS; s++)
                    if (slot_state[s] == SL_READY) slot_state[s] <= SL_EMPTY;
                end
              end
              default: ;
            endcase
          end
        end
        S_TRK: begin
          out_valid <= 1'b0;
          if (tracker_end[ts] == cur.read_offset) begin
            pick <= ts; found <= 1'b1;
          end
          if (tracker_streak[ts] < tracker_streak[cold]) cold <= ts;
          if (idx == SCAN_W'(TRACKERS - 1)) state <= S_UPD;
          else idx <= idx + 1'b1;
        end
        S_UPD: begin
          logic [TRK_W-1:0] p;
          logic [15:0] ns;
          p = found ? pick : cold;
          if (tracker_end[p] == cur.read_offset)
            ns = (tracker_streak[p] == 16'hFFFF) ? 16'hFFFF : tracker_streak[p] + 16'd1;
          else ns = 16'd1;
          out_valid <= 1'b0;
          pick <= p;
          tracker_streak[p] <= ns;
          tracker_end[p] <= cur.read_offset + 48'(cur.read_length);
          streak <= ns;
          read_clock <= read_clock + 32'd1;
          idx <= '0; slot_hit <= 1'b0;
          state <= ring_open ? S_SLOT : S_DEC;
        end
        S_SLOT: begin
          out_valid <= 1'b0;
          if (!slot_hit && slot_offset[ss] == cur.read_offset &&
              slot_state[ss] != SL_EMPTY && cur.read_length <= slot_length[ss]) begin
            slot_hit <= 1'b1; hit_slot <= ss;
          end
          if (idx == SCAN_W'(SLOTS - 1)) state <= S_DEC;
          else idx <= idx + 1'b1;
        end
        S_DEC: begin
          out_word_t w;
          fsm_t nx;
          logic grow;
          w = '0;
          w.kind = KIND_MISS;
          nx = S_EMIT;
          grow = 1'b0;
          if (!ring_open) begin
            if (!(streak < 16'(arm_streak) || !ring_enable)) begin
              ring_open <= 1'b1;
              depth_limit <= DEPTH_W'(MIN_DEPTH);
              next_fetch_offset <= tracker_end[pick];
              last_consume_clock <= read_clock;
              nx = S_PUMP;
            end
          end else if (slot_hit && slot_state[hit_slot] == SL_READY) begin
            slot_state[hit_slot] <= SL_EMPTY;
            last_consume_clock <= read_clock;
            w.kind = KIND_HIT; w.slot = 3'(hit_slot);
            nx = S_PUMP;
          end else if (slot_hit && !slot_waiting[hit_slot]) begin
            w.kind = KIND_PARK; w.slot = 3'(hit_slot);
            slot_waiting[hit_slot] <= 1'b1;
            waiter_tag[hit_slot] <= cur.request_tag;
            waiter_length[hit_slot] <= cur.read_length;
            last_consume_clock <= read_clock;
            grow = 1'b1; nx = S_PUMP;
          end else if (streak >= 16'(arm_streak) &&
                       (read_clock - last_consume_clock) > 32'(reaim_idle_reads)) begin
            ring_generation <= ring_generation + 8'd1;
            for (int s = 0; s < SLOTS; s++)
              if (slot_state[s] == SL_READY) slot_state[s] <= SL_EMPTY;
            next_fetch_offset <= tracker_end[pick];
            last_consume_clock <= read_clock;
            nx = S_PUMP;
          end
          out_valid <= 1'b0;
          pend <= w;
          pend_v <= 1'b1;
          pidx <= '0;
          pump_after_depth <= grow;
          state <= nx;
        end
        S_PUMP: begin
          if (pidx < (SLOT_W+1)'(depth_limit) && prsp.more) begin
            if (slot_state[ps] == SL_EMPTY) begin
              slot_offset[ps] <= next_fetch_offset;
              slot_length[ps] <= prsp.len;
              slot_state[ps] <= SL_FLIGHT;
              slot_generation[ps] <= ring_generation;
              next_fetch_offset <= prsp.off_next;
              out_valid <= pend_v;
              out_word <= pend;
              pend.kind <= KIND_ISSUE; pend.slot <= 3'(ps);
              pend.fetch_offset <= next_fetch_offset;
              pend.byte_count <= prsp.len;
              pend.done_tag <= '0; pend.done_ok <= 1'b0; pend.last <= 1'b0;
              pend_v <= 1'b1;
            end else begin
              out_valid <= 1'b0;
            end
            if (pidx == (SLOT_W+1)'(SLOTS - 1)) state <= S_EMIT;
            else pidx <= pidx + 1'b1;
          end else begin
            out_valid <= 1'b0;
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (pump_after_depth && depth_limit < DEPTH_W'(SLOTS))
            depth_limit <= depth_limit + 1'b1;
          pump_after_depth <= 1'b0;
          out_valid <= pend_v;
          out_word <= {pend[$bits(out_word_t)-1:1], 1'b1};
          pend_v <= 1'b0;
          state <= S_IDLE;
        end
        default: begin
          out_valid <= 1'b0;
          state <= S_IDLE;
        end
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.last |=> !out_valid) else $error("word after last");
  assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy || !out_valid) else $error("accept mismatch");
  assert property (@(posedge clk) disable iff (rst)
    depth_limit >= DEPTH_W'(1) && depth_limit <= DEPTH_W'(SLOTS)) else $error("depth");
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.kind == KIND_ISSUE |-> out_word.byte_count != '0)
    else $error("empty issue");

endmodule
`default_nettype wire

// ===== design/srpr_pump.sv =====
// ----------------------------------------------------------------------------
// srpr_pump
// Chunk unit: subtract and compares giving the next fetch length and offset.
// ----------------------------------------------------------------------------
`default_nettype none
module srpr_pump (
  input  var srpr_pkg::pump_req_t req,
  output srpr_pkg::pump_rsp_t     rsp
);
  import srpr_pkg::*;
  logic [47:0] rem;
  always_comb begin
    rem          = req.file_size - req.next_off;
    rsp.more     = req.next_off < req.file_size;
    rsp.len      = (rem < 48'(CHUNK_BYTES)) ? rem[20:0] : 21'(CHUNK_BYTES);
    rsp.off_next = req.next_off + 48'(rsp.len);
  end
endmodule
`default_nettype wire
